// File: rtl/msd_pkg.sv
// Package: shared types and codes for the mode selectable deque.
package msd_pkg;

	typedef enum logic [2:0] {
		OP_ADD_BACK,
		OP_ADD_FRONT,
		OP_DISPENSE,
		OP_DISPENSE_BACK,
		OP_PEEK,
		OP_PEEK_BACK,
		OP_IS_EMPTY,
		OP_CLEAR
	} op_t;

	typedef enum logic [2:0] {
		ST_OK,
		ST_EMPTY,
		ST_MODE,
		ST_FULL,
		ST_INVALID
	} status_t;

	typedef enum logic [0:0] {
		S_IDLE,
		S_READ
	} state_t;

	localparam logic [1:0] MODE_FIFO  = 2'd0;
	localparam logic [1:0] MODE_LIFO  = 2'd1;
	localparam logic [1:0] MODE_DEQUE = 2'd2;

	localparam int unsigned LEN_W    = 8;
	localparam int unsigned OP_W     = 3;
	localparam int unsigned STATUS_W = 3;
	localparam int unsigned COUNT_W  = 5;
	localparam int unsigned MODE_W   = 2;

endpackage

// File: rtl/msd_if.sv
// Interfaces: request, response and configuration channels of the deque.
interface msd_req_if #(
	parameter int unsigned WORD_WIDTH = 32
);
	logic                  valid;
	logic                  ready;
	logic [2:0]            op;
	logic [WORD_WIDTH-1:0] item_word;
	logic [7:0]            item_length;

	modport source (output valid, op, item_word, item_length, input ready);
	modport sink   (input valid, op, item_word, item_length, output ready);
endinterface

interface msd_rsp_if #(
	parameter int unsigned WORD_WIDTH = 32
);
	logic                  valid;
	logic                  ready;
	logic [2:0]            status;
	logic [WORD_WIDTH-1:0] out_word;
	logic [7:0]            out_length;
	logic                  empty_flag;
	logic [4:0]            entry_count;

	modport source (output valid, status, out_word, out_length, empty_flag, entry_count,
		input ready);
	modport sink   (input valid, status, out_word, out_length, empty_flag, entry_count,
		output ready);
endinterface

interface msd_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] mode;

	modport source (output valid, mode, input ready);
	modport sink   (input valid, mode, output ready);
endinterface

// File: rtl/mode_selectable_deque.sv
// Top level: bounded deque of tagged words with fifo, lifo and deque modes.
//
// Channels: req carries one operation word (op, item_word, item_length);
// rsp returns exactly one result word per request (status, out_word,
// out_length, empty_flag, entry_count); cfg writes the mode register
// (0 fifo, 1 lifo, 2 deque; 3 acts as lifo). cfg is always ready.
// Entries live in a single-port-write, registered-read memory of DEPTH words.
// Response: add, is-empty, clear and every refused request load the response
// register on acceptance. A successful dispense or peek first reads the memory
// into the read register, then loads the response register from it.
// Flow: no new request is taken while a memory read is pending, and a request
// is taken only while the response register is free or being drained in the
// same cycle.
// Reset: head pointer, count, mode and response valid clear; memory contents
// are not cleared and are only read where written.
// Stall: while rsp is held, the response register keeps its word and req is
// not accepted.
module mode_selectable_deque #(
	parameter int unsigned DEPTH      = 16,
	parameter int unsigned WORD_WIDTH = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	msd_cfg_if.sink   cfg,
	msd_req_if.sink   req,
	msd_rsp_if.source rsp
);
	import msd_pkg::*;

	localparam int unsigned PW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned EW = WORD_WIDTH + LEN_W;
	localparam logic [PW-1:0] LAST  = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULLC = CW'(DEPTH);

	logic [EW-1:0] mem [DEPTH];
	logic [EW-1:0] rdata_q;

	state_t                state_q, state_d;
	logic [PW-1:0]         head_q, head_d;
	logic [CW-1:0]         count_q, count_d;
	logic [MODE_W-1:0]     mode_q;

	logic                  rsp_valid_q;
	status_t               rsp_status_q;
	logic [WORD_WIDTH-1:0] rsp_word_q;
	logic [LEN_W-1:0]      rsp_len_q;
	logic                  rsp_empty_q;
	logic [COUNT_W-1:0]    rsp_count_q;

	logic                  req_fire;
	op_t                   op;
	logic                  front;
	logic [CW:0]           sum;
	logic [PW-1:0]         tail_idx, back_idx, head_inc, head_dec;
	logic                  mem_we, mem_re;
	logic [PW-1:0]         mem_waddr, mem_raddr;
	logic                  ld;
	status_t               st_d;
	logic [WORD_WIDTH-1:0] word_d;
	logic [LEN_W-1:0]      len_d;
	logic [CW+COUNT_W-1:0] count_ext;

	assign cfg.ready = 1'b1;
	assign req.ready = (state_q == S_IDLE) && (!rsp_valid_q || rsp.ready);
	assign req_fire  = req.valid && req.ready;
	assign op        = op_t'(req.op);

	assign sum      = (CW+1)'(head_q) + (CW+1)'(count_q);
	assign tail_idx = (sum >= (CW+1)'(DEPTH)) ? PW'(sum - (CW+1)'(DEPTH)) : PW'(sum);
	assign back_idx = (tail_idx == '0) ? LAST : tail_idx - PW'(1);
	assign head_inc = (head_q == LAST) ? '0 : head_q + PW'(1);
	assign head_dec = (head_q == '0) ? LAST : head_q - PW'(1);
	assign front    = (op == OP_DISPENSE || op == OP_PEEK) && mode_q == MODE_FIFO;

	always_comb begin
		state_d   = state_q;
		head_d    = head_q;
		count_d   = count_q;
		mem_we    = 1'b0;
		mem_waddr = tail_idx;
		mem_re    = 1'b0;
		mem_raddr = front ? head_q : back_idx;
		ld        = 1'b0;
		st_d      = ST_OK;
		word_d    = '0;
		len_d     = '0;
		case (state_q)
			S_IDLE: begin
				if (req_fire) begin
					ld = 1'b1;
					case (op)
						OP_ADD_BACK, OP_ADD_FRONT: begin
							if (req.item_length == '0) begin
								st_d = ST_INVALID;
							end else if (count_q == FULLC) begin
								st_d = ST_FULL;
							end else begin
								mem_we  = 1'b1;
								count_d = count_q + CW'(1);
								if (op == OP_ADD_FRONT) begin
									head_d    = head_dec;
									mem_waddr = head_dec;
								end
							end
						end
						OP_DISPENSE, OP_DISPENSE_BACK, OP_PEEK, OP_PEEK_BACK: begin
							if (count_q == '0) begin
								st_d = ST_EMPTY;
							end else if ((op == OP_DISPENSE_BACK || op == OP_PEEK_BACK)
								&& mode_q != MODE_DEQUE) begin
								st_d = ST_MODE;
							end else begin
								ld      = 1'b0;
								mem_re  = 1'b1;
								state_d = S_READ;
								if (op == OP_DISPENSE || op == OP_DISPENSE_BACK) begin
									count_d = count_q - CW'(1);
									if (front) begin
										head_d = head_inc;
									end
								end
							end
						end
						OP_IS_EMPTY: begin
							st_d = ST_OK;
						end
						OP_CLEAR: begin
							head_d  = '0;
							count_d = '0;
						end
						default: begin
							st_d = ST_OK;
						end
					endcase
				end
			end
			S_READ: begin
				ld      = 1'b1;
				word_d  = rdata_q[EW-1:LEN_W];
				len_d   = rdata_q[LEN_W-1:0];
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign count_ext = {{COUNT_W{1'b0}}, count_d};

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= {req.item_word, req.item_length};
		end
		if (mem_re) begin
			rdata_q <= mem[mem_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			count_q     <= '0;
			mode_q      <= MODE_FIFO;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			count_q <= count_d;
			if (cfg.valid) begin
				mode_q <= cfg.mode;
			end
			if (ld) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			rsp_status_q <= st_d;
			rsp_word_q   <= word_d;
			rsp_len_q    <= len_d;
			rsp_empty_q  <= (count_d == '0);
			rsp_count_q  <= count_ext[COUNT_W-1:0];
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = rsp_status_q;
	assign rsp.out_word    = rsp_word_q;
	assign rsp.out_length  = rsp_len_q;
	assign rsp.empty_flag  = rsp_empty_q;
	assign rsp.entry_count = rsp_count_q;

endmodule

// File: rtl/msd_checker.sv
// Checker: port-level assertions on the deque, bound to the top level.
module msd_checker #(
	parameter int unsigned DEPTH = 16
) (
	input logic       clk,
	input logic       arst_n,
	input logic       req_valid,
	input logic       req_ready,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic [2:0] status,
	input logic       empty_flag,
	input logic [4:0] entry_count
);
	import msd_pkg::*;

	localparam logic [4:0] FULL_CNT = 5'(DEPTH);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response word dropped while stalled");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> rsp_valid || !req_ready)
		else $error("request taken with no response pending");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && DEPTH < 32 |-> empty_flag == (entry_count == 5'd0))
		else $error("empty flag disagrees with count");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == ST_FULL |-> entry_count == FULL_CNT)
		else $error("full status with store not full");

	a_empty_status: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == ST_EMPTY |-> empty_flag)
		else $error("empty status with entries held");

endmodule

bind mode_selectable_deque msd_checker #(.DEPTH(DEPTH)) u_msd_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req.valid),
	.req_ready   (req.ready),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.status      (rsp.status),
	.empty_flag  (rsp.empty_flag),
	.entry_count (rsp.entry_count)
);
